/* rtl/core/ris_pkg.sv */
// Shared types, constants and the sort-key compare for the rectangle insertion sorter.
// Depends on nothing; every other file of the block imports it.
package ris_pkg;

   localparam int MAX_RECTS = 16;
   localparam int EDGE_W    = 16;
   localparam int COUNT_W   = $clog2(MAX_RECTS + 1);

   typedef struct packed {
      logic signed [EDGE_W-1:0] left;
      logic signed [EDGE_W-1:0] top;
      logic signed [EDGE_W-1:0] right;
      logic signed [EDGE_W-1:0] bottom;
   } rect_type;

   typedef enum logic {
      ST_COLLECT,
      ST_EMIT
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic insert;     // store the incoming rectangle in sorted position
      logic drop_mark;  // table is full: note that the rectangle was dropped
      logic shift_out;  // the head entry was delivered: move the table up by one
      logic clear_flag; // end of run: clear the drop flag
   } ris_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic full;       // every entry holds a rectangle
      logic count_one;  // exactly one entry remains
   } ris_status_type;

   // True when stored rectangle a must sit behind new rectangle b.
   // Equal keys return false, which keeps arrival order among equals.
   function automatic logic goes_after(input rect_type a, input rect_type b);
      logic result;
      if (a.left != b.left) begin
         result = (a.left > b.left);
      end else begin
         result = (a.top > b.top);
      end
      return result;
   endfunction

endpackage

/* rtl/core/ris_req_if.sv */
// Request channel of the rectangle insertion sorter: valid/ready plus one rectangle.
// Depends on ris_pkg for the edge width.
interface ris_req_if
   import ris_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic signed [EDGE_W-1:0] rect_left;
   logic signed [EDGE_W-1:0] rect_top;
   logic signed [EDGE_W-1:0] rect_right;
   logic signed [EDGE_W-1:0] rect_bottom;
   logic                     last_in;

   modport source (output valid, rect_left, rect_top, rect_right, rect_bottom, last_in,
                   input ready);
   modport sink   (input valid, rect_left, rect_top, rect_right, rect_bottom, last_in,
                   output ready);
endinterface

/* rtl/core/ris_rsp_if.sv */
// Response channel of the rectangle insertion sorter: valid/ready plus one sorted rectangle.
// Depends on ris_pkg for the edge width.
interface ris_rsp_if
   import ris_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic signed [EDGE_W-1:0] out_left;
   logic signed [EDGE_W-1:0] out_top;
   logic signed [EDGE_W-1:0] out_right;
   logic signed [EDGE_W-1:0] out_bottom;
   logic                     last_out;
   logic                     overflow;

   modport source (output valid, out_left, out_top, out_right, out_bottom, last_out,
                   overflow, input ready);
   modport sink   (input valid, out_left, out_top, out_right, out_bottom, last_out,
                   overflow, output ready);
endinterface

/* rtl/core/ris_datapath.sv */
// Datapath of the rectangle insertion sorter: a row of sorting cells, the fill count
// and the drop flag. Depends on ris_pkg; driven by ris_controller commands.
module ris_datapath
   import ris_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  ris_cmd_type    cmd,
   input  rect_type       new_rect,
   output ris_status_type status,
   output rect_type       head_rect,
   output logic           overflow
);

   rect_type           cell_ff [MAX_RECTS];
   rect_type           cell_in [MAX_RECTS];
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic               dropped_ff;
   logic               dropped_in;
   logic [MAX_RECTS-1:0] behind;

   // Each cell compares its entry with the new key; the results are monotone
   // over the valid cells because the table is sorted.
   always_comb begin
      for (int i = 0; i < MAX_RECTS; i++) begin
         behind[i] = (count_ff > COUNT_W'(i)) && goes_after(cell_ff[i], new_rect);
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_RECTS; i++) begin
         cell_in[i] = cell_ff[i];
         if (cmd.insert) begin
            if (count_ff == COUNT_W'(i)) begin
               // First free cell: takes the neighbor moving down, or the new entry.
               if (i > 0 && behind[(i > 0) ? i - 1 : 0]) begin
                  cell_in[i] = cell_ff[(i > 0) ? i - 1 : 0];
               end else begin
                  cell_in[i] = new_rect;
               end
            end else if (behind[i]) begin
               if (i > 0 && behind[(i > 0) ? i - 1 : 0]) begin
                  cell_in[i] = cell_ff[(i > 0) ? i - 1 : 0];
               end else begin
                  cell_in[i] = new_rect;
               end
            end
         end else if (cmd.shift_out) begin
            if (i < MAX_RECTS - 1) begin
               cell_in[i] = cell_ff[(i < MAX_RECTS - 1) ? i + 1 : i];
            end
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.insert) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (cmd.shift_out) begin
         count_in = count_ff - COUNT_W'(1);
      end
      dropped_in = dropped_ff;
      if (cmd.drop_mark) begin
         dropped_in = 1'b1;
      end else if (cmd.clear_flag) begin
         dropped_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RECTS; i++) begin
         cell_ff[i] <= cell_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
      end
   end

   assign status.full      = (count_ff == COUNT_W'(MAX_RECTS));
   assign status.count_one = (count_ff == COUNT_W'(1));
   assign head_rect        = cell_ff[0];
   assign overflow         = dropped_ff;

endmodule

/* rtl/core/ris_controller.sv */
// Controller of the rectangle insertion sorter: collects a set, then emits it.
// Depends on ris_pkg; steers ris_datapath through command and status structs.
module ris_controller
   import ris_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_last,
   input  logic           rsp_ready,
   input  ris_status_type status,
   output logic           req_ready,
   output logic           rsp_valid,
   output ris_cmd_type    cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_COLLECT: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.insert    = !status.full;
               cmd.drop_mark = status.full;
               if (req_last) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.shift_out = 1'b1;
               if (status.count_one) begin
                  cmd.clear_flag = 1'b1;
                  state_in       = ST_COLLECT;
               end
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

endmodule

/* rtl/core/rect_insertion_sorter.sv */
// Top level of the rectangle insertion sorter.
// Depends on ris_pkg, ris_req_if, ris_rsp_if, ris_controller and ris_datapath.
//
// Usage: rectangles arrive one per transaction on req_ch (four signed edges and
// last_in). Each is inserted into a row of MAX_RECTS sorting cells, ordered by
// left edge and then top edge; equal keys keep their arrival order. On insertion,
// every cell compares its key with the new one in parallel and either holds,
// takes its neighbor, or takes the new rectangle, so req_ch accepts one
// transaction per cycle while a set is being collected.
// When the transaction flagged last_in is accepted, the block stops taking
// requests and emits the sorted set on rsp_ch, one rectangle per transaction,
// starting the cycle after. Results come straight from the head cell, which is
// a register, and the row shifts up by one on each accepted response; the last
// one carries last_out. Once the last response is taken, requests are accepted
// again on the next cycle. A stalled receiver simply holds the head response.
// Rectangles beyond MAX_RECTS are dropped and overflow is set on every response
// of that run; last_in on a dropped rectangle still starts the emit.
// Reset (synchronous, active high) empties the table and clears the drop flag.
module rect_insertion_sorter
   import ris_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   ris_req_if.sink   req_ch,
   ris_rsp_if.source rsp_ch
);

   ris_cmd_type    cmd;
   ris_status_type status;
   rect_type       new_rect;
   rect_type       head_rect;
   logic           overflow;

   assign new_rect.left   = req_ch.rect_left;
   assign new_rect.top    = req_ch.rect_top;
   assign new_rect.right  = req_ch.rect_right;
   assign new_rect.bottom = req_ch.rect_bottom;

   // The controller decides when to insert, drop and shift; the datapath holds the cells.
   ris_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_last  (req_ch.last_in),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .cmd       (cmd)
   );

   ris_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .new_rect  (new_rect),
      .status    (status),
      .head_rect (head_rect),
      .overflow  (overflow)
   );

   // The response always shows the head cell; last_out marks the final entry.
   assign rsp_ch.out_left   = head_rect.left;
   assign rsp_ch.out_top    = head_rect.top;
   assign rsp_ch.out_right  = head_rect.right;
   assign rsp_ch.out_bottom = head_rect.bottom;
   assign rsp_ch.last_out   = status.count_one;
   assign rsp_ch.overflow   = overflow;

endmodule

/* dv/tb_rect_insertion_sorter.sv */
`timescale 1ns / 100ps
// Testbench for rect_insertion_sorter: directed and random rectangle sets, checked against a
// behavioral insertion sort. Depends on ris_pkg, ris_req_if, ris_rsp_if and the block itself.
module tb_rect_insertion_sorter;
   import ris_pkg::*;

   // Longest run of cycles with no transaction on either channel before the run is abandoned.
   localparam int WATCHDOG_LIMIT = 1000;
   // Cycles allowed after the last sorted rectangle arrives so that a stray extra one shows up.
   localparam int DRAIN_CYCLES   = 20;
   localparam int RANDOM_ITEMS   = 240;

   // One expected sorted rectangle together with the run markers that travel with it.
   typedef struct {
      rect_type rect;
      logic     last;
      logic     overflow;
   } sorted_rsp_type;

   logic clock;
   logic reset;

   ris_req_if req_bus ();
   ris_rsp_if rsp_bus ();

   rect_insertion_sorter dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   // Behavioral copy of the sorting table: the rectangles of the set being collected, in
   // sorted order, how many there are, and whether any were turned away because it was full.
   rect_type       stored_rects [MAX_RECTS];
   int             stored_count;
   logic           rects_dropped;
   // Sorted rectangles that the block still owes, oldest first.
   sorted_rsp_type sorted_rect_q [$];

   // Upper bounds for the per-transaction idle draws on each side; tests change these to get
   // both busy stretches and stretches with no idling at all.
   int req_gap_max;
   int rsp_stall_max;

   int fail_count;
   int idle_cycles;
   int sets_done;
   int rects_checked;
   int overflow_runs;
   int random_items;
   logic           progress;
   rect_type       seen_rect;
   sorted_rsp_type want;

   // 8 ns clock: four low, four high.
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Predictor for one accepted rectangle. It is inserted behind every stored rectangle whose
   // key is not larger, so equal keys keep their arrival order. A rectangle that finds the
   // table full is lost, but its last flag still closes the set. Closing the set queues the
   // whole table as expected results and empties it.
   task automatic predict_insert(input rect_type cur, input logic last);
      int             pos;
      int             i;
      sorted_rsp_type item;
      if (stored_count < MAX_RECTS) begin
         pos = stored_count;
         while (pos > 0 && ((stored_rects[pos-1].left > cur.left) ||
                            (stored_rects[pos-1].left == cur.left &&
                             stored_rects[pos-1].top > cur.top))) begin
            stored_rects[pos] = stored_rects[pos-1];
            pos--;
         end
         stored_rects[pos] = cur;
         stored_count++;
      end else begin
         rects_dropped = 1'b1;
      end
      if (last) begin
         for (i = 0; i < stored_count; i++) begin
            item.rect     = stored_rects[i];
            item.last     = (i == stored_count - 1);
            item.overflow = rects_dropped;
            sorted_rect_q = {sorted_rect_q, item};
         end
         if (rects_dropped) begin
            overflow_runs++;
         end
         sets_done++;
         stored_count  = 0;
         rects_dropped = 1'b0;
      end
   endtask

   task automatic check_field(input string name, input logic signed [EDGE_W-1:0] want_val,
                              input logic signed [EDGE_W-1:0] got_val);
      if (got_val !== want_val) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want_val, got_val);
         fail_count++;
      end
   endtask

   task automatic check_flag(input string name, input logic want_val, input logic got_val);
      if (got_val !== want_val) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want_val, got_val);
         fail_count++;
      end
   endtask

   // Monitor. Everything is sampled at the rising edge, before the block's registers update.
   // A response transaction is checked before a request transaction of the same cycle is fed
   // to the predictor, since a response always belongs to an earlier set.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         progress = 1'b0;
         if (rsp_bus.valid && rsp_bus.ready) begin
            progress = 1'b1;
            rects_checked++;
            if (sorted_rect_q.size() == 0) begin
               $error("sorted rectangle arrived with none expected: left %0d top %0d",
                      rsp_bus.out_left, rsp_bus.out_top);
               fail_count++;
            end else begin
               want = sorted_rect_q.pop_front();
               check_field("out_left",   want.rect.left,   rsp_bus.out_left);
               check_field("out_top",    want.rect.top,    rsp_bus.out_top);
               check_field("out_right",  want.rect.right,  rsp_bus.out_right);
               check_field("out_bottom", want.rect.bottom, rsp_bus.out_bottom);
               check_flag("last_out",    want.last,        rsp_bus.last_out);
               check_flag("overflow",    want.overflow,    rsp_bus.overflow);
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            progress         = 1'b1;
            seen_rect.left   = req_bus.rect_left;
            seen_rect.top    = req_bus.rect_top;
            seen_rect.right  = req_bus.rect_right;
            seen_rect.bottom = req_bus.rect_bottom;
            predict_insert(seen_rect, req_bus.last_in);
         end
         // The watchdog only sees cycles in which no transaction completed on either side.
         if (progress) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // Receiver. Before each response transaction it holds ready low for a random number of
   // cycles, then keeps it high until a rectangle is taken. Changes happen at the falling edge.
   initial begin : rsp_receiver
      int stall;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset) begin
         @(negedge clock);
      end
      forever begin
         stall = $urandom_range(0, rsp_stall_max);
         if (stall != 0) begin
            rsp_bus.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready = 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         @(negedge clock);
      end
   end

   // Sends one rectangle as a request transaction. Valid is lowered only when an idle gap is
   // drawn, so back-to-back rectangles keep valid high without a glitch.
   task automatic send_rect(input rect_type r, input logic last);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      @(negedge clock);
      if (gap != 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.rect_left   = r.left;
      req_bus.rect_top    = r.top;
      req_bus.rect_right  = r.right;
      req_bus.rect_bottom = r.bottom;
      req_bus.last_in     = last;
      req_bus.valid       = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Builds a rectangle from four literal edges; keeps the directed tests compact.
   function automatic rect_type mk_rect(input int l, input int t, input int r, input int b);
      rect_type x;
      x.left   = EDGE_W'(l);
      x.top    = EDGE_W'(t);
      x.right  = EDGE_W'(r);
      x.bottom = EDGE_W'(b);
      return x;
   endfunction

   // One edge value: the full range, the extremes and zero, or a narrow band around zero so
   // that keys collide often and the tie-break and stability paths get exercised.
   function automatic logic signed [EDGE_W-1:0] draw_edge();
      logic signed [EDGE_W-1:0] v;
      case ($urandom_range(0, 3))
         0: begin
            case ($urandom_range(0, 3))
               0: v = 16'sh8000;
               1: v = 16'sh7fff;
               2: v = 16'sh0000;
               default: v = 16'shffff;
            endcase
         end
         1: begin
            v = EDGE_W'($signed($urandom_range(0, 6)) - 3);
         end
         default: begin
            v = EDGE_W'($urandom_range(0, 16'hffff));
         end
      endcase
      return v;
   endfunction

   // Extreme edge values, a left-edge tie broken by the top edge, and two rectangles with the
   // same key that must come out in arrival order.
   task automatic test_edge_extremes();
      req_gap_max   = 0;
      rsp_stall_max = 0;
      send_rect(mk_rect(0, 0, 0, 0), 1'b0);
      send_rect(mk_rect(32767, -32768, 32767, -32768), 1'b0);
      send_rect(mk_rect(-32768, 32767, -32768, 32767), 1'b0);
      send_rect(mk_rect(-32768, -32768, 0, -1), 1'b0);
      send_rect(mk_rect(0, 0, 1, 1), 1'b0);
      send_rect(mk_rect(-1, 5, -1, -1), 1'b0);
      send_rect(mk_rect(32767, 32767, 0, 0), 1'b0);
      send_rect(mk_rect(0, -1, 2, 2), 1'b1);
   endtask

   // A set of a single rectangle, then a pair where the second lands in front of the first.
   task automatic test_short_sets();
      req_gap_max   = 4;
      rsp_stall_max = 4;
      send_rect(mk_rect(-1, -1, -1, -1), 1'b1);
      send_rect(mk_rect(100, 7, 200, 300), 1'b0);
      send_rect(mk_rect(-100, 7, -50, 20), 1'b1);
   endtask

   // Fills the table in descending order so every insertion shifts the whole row, then sends
   // one more rectangle flagged last: it is dropped, yet the stored set is still emitted with
   // overflow set on each result.
   task automatic test_table_overflow();
      int i;
      req_gap_max   = 0;
      rsp_stall_max = 2;
      for (i = 0; i < MAX_RECTS; i++) begin
         send_rect(mk_rect(1000 - 10 * i, i % 3, i, -i), 1'b0);
      end
      send_rect(mk_rect(-5000, 0, 1, 1), 1'b1);
   endtask

   // Random sets. Most fit the table, some exactly fill it and a few overrun it. Idle limits
   // change from set to set so that some stretches run with no idling on either side.
   task automatic test_random_sets();
      int       set_len;
      int       i;
      rect_type r;
      while (random_items < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0:       set_len = MAX_RECTS;
            1:       set_len = $urandom_range(MAX_RECTS + 1, MAX_RECTS + 6);
            2, 3:    set_len = $urandom_range(1, 3);
            default: set_len = $urandom_range(1, MAX_RECTS);
         endcase
         req_gap_max   = ($urandom_range(0, 2) == 0) ? 0 : 4;
         rsp_stall_max = ($urandom_range(0, 2) == 0) ? 0 : 4;
         for (i = 0; i < set_len; i++) begin
            r.left   = draw_edge();
            r.top    = draw_edge();
            r.right  = EDGE_W'($urandom_range(0, 16'hffff));
            r.bottom = EDGE_W'($urandom_range(0, 16'hffff));
            send_rect(r, i == set_len - 1);
            random_items++;
         end
      end
   endtask

   initial begin
      fail_count          = 0;
      sets_done           = 0;
      rects_checked       = 0;
      overflow_runs       = 0;
      random_items        = 0;
      stored_count        = 0;
      rects_dropped       = 1'b0;
      req_gap_max         = 0;
      rsp_stall_max       = 0;
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.rect_left   = '0;
      req_bus.rect_top    = '0;
      req_bus.rect_right  = '0;
      req_bus.rect_bottom = '0;
      req_bus.last_in     = 1'b0;

      // Synchronous reset, released at a falling edge.
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_edge_extremes();
      test_short_sets();
      test_table_overflow();
      test_random_sets();

      @(negedge clock);
      req_bus.valid = 1'b0;
      // Wait for every owed rectangle; the watchdog ends the run if they never come.
      while (sorted_rect_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sorted %0d rectangle sets (%0d with dropped rectangles), %0d results checked.",
               sets_done, overflow_runs, rects_checked);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

/* rect_insertion_sorter.f */
rtl/core/ris_pkg.sv
rtl/core/ris_req_if.sv
rtl/core/ris_rsp_if.sv
rtl/core/ris_datapath.sv
rtl/core/ris_controller.sv
rtl/core/rect_insertion_sorter.sv
dv/tb_rect_insertion_sorter.sv
